/* design/dds_pkg.sv */
// Shared constants, types and helpers of the directional difference stencil.
package dds_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int MAX_OFFSET   = 2;
  localparam int MAX_DIRS     = 4;
  localparam int TABLE_DIRS   = 4;
  localparam int PIXEL_BITS   = 16;
  localparam int EFF_DIRS     = (MAX_DIRS < TABLE_DIRS) ? MAX_DIRS : TABLE_DIRS;

  localparam int MAX_LAG    = MAX_OFFSET * MAX_WIDTH + MAX_OFFSET;
  localparam int RING_DEPTH = 2 * MAX_LAG + 1;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int LAG_W      = $clog2(MAX_LAG + 1);
  localparam int POS_W      = $clog2(MAX_WIDTH * HEIGHT_LIMIT + MAX_LAG + 1);

  localparam int DIM_W  = 11;
  localparam int CNT_W  = 10;
  localparam int DIR_W  = 2;
  localparam int DIRS_W = 3;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int DIFF_W = 17;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_DIRS   = 3'd2,
    REG_DX     = 3'd3,
    REG_DY     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [DIRS_W-1:0] dirs;
    logic [CFG_W-1:0]  dx_table;
    logic [CFG_W-1:0]  dy_table;
  } geom_t;

  typedef struct packed {
    logic [ADDR_W-1:0] centre_addr;
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
  } centre_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [DIR_W-1:0]         dir;
    logic [CNT_W-1:0]         row;
    logic [CNT_W-1:0]         col;
    logic                     last;
  } result_t;

  function automatic logic signed [3:0] table_offset(logic [CFG_W-1:0] tbl,
                                                     logic [DIR_W-1:0] idx);
    logic signed [3:0] v;
    v = $signed(tbl[idx*4 +: 4]);
    if (int'(v) > MAX_OFFSET) v = 4'(MAX_OFFSET);
    if (int'(v) < -MAX_OFFSET) v = 4'(-MAX_OFFSET);
    return v;
  endfunction

endpackage

/* design/dds_if.sv */
// Pixel input and result output channel interfaces.
interface dds_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dds_pkg::PIXEL_BITS-1:0] pixel_value;
  logic                                  pad;
  modport source(output valid, pixel_value, pad, input ready);
  modport sink(input valid, pixel_value, pad, output ready);
endinterface

interface dds_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dds_pkg::DIFF_W-1:0] difference;
  logic [dds_pkg::DIR_W-1:0]         direction_index;
  logic [dds_pkg::CNT_W-1:0]         centre_row;
  logic [dds_pkg::CNT_W-1:0]         centre_col;
  logic                              last;
  modport source(output valid, difference, direction_index, centre_row, centre_col, last,
                 input ready);
  modport sink(input valid, difference, direction_index, centre_row, centre_col, last,
               output ready);
endinterface

/* design/dds_ram.sv */
// Generic single-write, single-read RAM with registered read (read-first).
module dds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4101
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* design/dds_stream.sv */
// Configuration registers, raster position tracking and line store writes.
module dds_stream (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dds_pkg::IDX_W-1:0]            cfg_index,
  input  logic [dds_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 accept,
  input  logic signed [dds_pkg::PIXEL_BITS-1:0] pixel_value,
  input  logic                                 pad,
  output logic                                 run,
  output dds_pkg::geom_t                       geom,
  output logic                                 wr_en,
  output logic [dds_pkg::ADDR_W-1:0]           wr_addr,
  output logic [dds_pkg::PIXEL_BITS-1:0]       wr_data,
  output logic                                 load,
  output dds_pkg::centre_t                     centre
);
  import dds_pkg::*;

  localparam int AX_W = ADDR_W + 1;

  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_WAIT   = 3'b010,
    ST_DIVIDE = 3'b100
  } stream_state_t;

  stream_state_t     state;
  logic [1:0]        wait_cnt;
  logic [DIM_W-1:0]  width_reg, height_reg;
  logic [DIRS_W-1:0] dirs_reg;
  logic [CFG_W-1:0]  dx_reg, dy_reg;
  geom_t             geom_next;
  logic [POS_W-1:0]  pixels, total, pos, pos_eff, rem_q, rem_r;
  logic [LAG_W-1:0]  lag;
  logic [CNT_W-1:0]  row, col;
  logic [ADDR_W-1:0] waddr;
  logic              centre_ok, q_step, r_step;
  logic [AX_W-1:0]   caddr;

  always_comb begin
    geom_next.width = (width_reg == '0) ? DIM_W'(1) :
                      (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    geom_next.height = (height_reg == '0) ? DIM_W'(1) :
                       (height_reg > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : height_reg;
    geom_next.dirs = (dirs_reg == '0) ? DIRS_W'(1) :
                     (dirs_reg > DIRS_W'(EFF_DIRS)) ? DIRS_W'(EFF_DIRS) : dirs_reg;
    geom_next.dx_table = dx_reg;
    geom_next.dy_table = dy_reg;
  end

  always_ff @(posedge clk) begin
    geom   <= geom_next;
    pixels <= POS_W'(geom.width) * POS_W'(geom.height);
    lag    <= LAG_W'(MAX_OFFSET * geom.width + MAX_OFFSET);
    total  <= pixels + POS_W'(lag);
  end

  assign pos_eff   = (pos >= total) ? '0 : pos;
  assign centre_ok = pos >= POS_W'(lag);
  assign q_step    = rem_q >= POS_W'(geom.width);
  assign r_step    = rem_r >= POS_W'(RING_DEPTH);
  assign run       = state == ST_RUN;
  assign wr_en     = accept && (pos < pixels);
  assign wr_addr   = waddr;
  assign wr_data   = pad ? '0 : pixel_value;
  assign load      = accept && centre_ok;

  always_comb begin
    if ({1'b0, waddr} >= AX_W'(lag)) begin
      caddr = {1'b0, waddr} - AX_W'(lag);
    end else begin
      caddr = {1'b0, waddr} + AX_W'(RING_DEPTH) - AX_W'(lag);
    end
    centre.centre_addr = caddr[ADDR_W-1:0];
    centre.row = row;
    centre.col = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WAIT;
      wait_cnt   <= 2'd3;
      width_reg  <= DIM_W'(1024);
      height_reg <= DIM_W'(1024);
      dirs_reg   <= DIRS_W'(2);
      dx_reg     <= CFG_W'(1);
      dy_reg     <= CFG_W'(16);
      pos        <= '0;
      waddr      <= '0;
      row        <= '0;
      col        <= '0;
    end else begin
      if (cfg_we) begin
        state    <= ST_WAIT;
        wait_cnt <= 2'd3;
        case (cfg_index)
          REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
          REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
          REG_DIRS:   dirs_reg   <= cfg_data[DIRS_W-1:0];
          REG_DX:     dx_reg     <= cfg_data;
          REG_DY:     dy_reg     <= cfg_data;
          default: ;
        endcase
      end else begin
        unique case (state)
          ST_WAIT: begin
            if (wait_cnt == 2'd0) begin
              pos   <= pos_eff;
              rem_q <= (pos_eff >= POS_W'(lag)) ? pos_eff - POS_W'(lag) : '0;
              rem_r <= pos_eff;
              row   <= '0;
              state <= ST_DIVIDE;
            end else begin
              wait_cnt <= wait_cnt - 2'd1;
            end
          end
          ST_DIVIDE: begin
            if (q_step) begin
              rem_q <= rem_q - POS_W'(geom.width);
              row   <= row + CNT_W'(1);
            end
            if (r_step) rem_r <= rem_r - POS_W'(RING_DEPTH);
            if (!q_step && !r_step) begin
              col   <= rem_q[CNT_W-1:0];
              waddr <= rem_r[ADDR_W-1:0];
              state <= ST_RUN;
            end
          end
          ST_RUN: begin
            if (accept) begin
              if (pos + POS_W'(1) == total) begin
                pos   <= '0;
                waddr <= '0;
                row   <= '0;
                col   <= '0;
              end else begin
                pos   <= pos + POS_W'(1);
                waddr <= (waddr == ADDR_W'(RING_DEPTH - 1)) ? '0 : waddr + ADDR_W'(1);
                if (centre_ok) begin
                  if ({1'b0, col} == geom.width - DIM_W'(1)) begin
                    col <= '0;
                    row <= row + CNT_W'(1);
                  end else begin
                    col <= col + CNT_W'(1);
                  end
                end
              end
            end
          end
          default: state <= ST_WAIT;
        endcase
      end
    end
  end
endmodule

/* design/dds_issue.sv */
// Direction sequencer, neighbour address generation, difference and result queue.
module dds_issue (
  input  logic                             clk,
  input  logic                             rst,
  input  dds_pkg::geom_t                   geom,
  input  logic                             load,
  input  dds_pkg::centre_t                 centre,
  output logic                             free,
  output logic [dds_pkg::ADDR_W-1:0]       nbr_addr,
  output logic [dds_pkg::ADDR_W-1:0]       centre_addr,
  input  logic [dds_pkg::PIXEL_BITS-1:0]   nbr_data,
  input  logic [dds_pkg::PIXEL_BITS-1:0]   centre_data,
  dds_out_if.source                        result_out
);
  import dds_pkg::*;

  localparam int OFF_W = DIM_W + 6;

  logic                    busy, issue, last_dir, credit_ok, pop, inb;
  logic [DIR_W-1:0]        dir;
  centre_t                 cur;
  logic signed [3:0]       dx, dy;
  logic signed [DIM_W:0]   nr, nc;
  logic signed [OFF_W-1:0] off, sa, wrapped;
  logic                    r_valid, r_inb, r_last;
  logic [DIR_W-1:0]        r_dir;
  logic [CNT_W-1:0]        r_row, r_col;
  result_t                 res_in;
  result_t                 fifo [2];
  logic                    wr_ptr, rd_ptr;
  logic [1:0]              count;
  logic [2:0]              level;

  assign dx       = table_offset(geom.dx_table, dir);
  assign dy       = table_offset(geom.dy_table, dir);
  assign last_dir = {1'b0, dir} == geom.dirs - DIRS_W'(1);
  assign pop      = result_out.valid && result_out.ready;
  assign level    = {1'b0, count} + {2'b00, r_valid} - {2'b00, pop};
  assign credit_ok = level < 3'd2;
  assign issue    = busy && credit_ok;
  assign free     = !busy || (issue && last_dir);

  always_comb begin
    nr  = $signed({2'b00, cur.row}) + (DIM_W+1)'(dy);
    nc  = $signed({2'b00, cur.col}) + (DIM_W+1)'(dx);
    inb = !nr[DIM_W] && (nr < $signed({1'b0, geom.height})) &&
          !nc[DIM_W] && (nc < $signed({1'b0, geom.width}));
    off = OFF_W'(dy) * $signed({6'b0, geom.width}) + OFF_W'(dx);
    sa  = $signed({4'b0, cur.centre_addr}) + off;
    if (sa < 0) begin
      wrapped = OFF_W'(sa + RING_DEPTH);
    end else if (sa >= RING_DEPTH) begin
      wrapped = OFF_W'(sa - RING_DEPTH);
    end else begin
      wrapped = sa;
    end
  end

  assign nbr_addr    = wrapped[ADDR_W-1:0];
  assign centre_addr = cur.centre_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      dir     <= '0;
      r_valid <= 1'b0;
    end else begin
      r_valid <= issue;
      if (load) begin
        busy <= 1'b1;
        dir  <= '0;
      end else if (issue) begin
        if (last_dir) busy <= 1'b0;
        dir <= dir + DIR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= centre;
    r_inb  <= inb;
    r_dir  <= dir;
    r_last <= last_dir;
    r_row  <= cur.row;
    r_col  <= cur.col;
  end

  always_comb begin
    res_in.diff = r_inb ? (DIFF_W'($signed(nbr_data)) - DIFF_W'($signed(centre_data))) : '0;
    res_in.dir  = r_dir;
    res_in.row  = r_row;
    res_in.col  = r_col;
    res_in.last = r_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (r_valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, r_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (r_valid) fifo[wr_ptr] <= res_in;
  end

  assign result_out.valid           = count != 2'd0;
  assign result_out.difference      = fifo[rd_ptr].diff;
  assign result_out.direction_index = fifo[rd_ptr].dir;
  assign result_out.centre_row      = fifo[rd_ptr].row;
  assign result_out.centre_col      = fifo[rd_ptr].col;
  assign result_out.last            = fifo[rd_ptr].last;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue overflow");
  a_read_follows: assert property (@(posedge clk) disable iff (rst) issue |=> r_valid)
    else $error("read data not captured after issue");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (issue && last_dir && !load) |=> !busy)
    else $error("sequencer did not finish after last direction");
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (issue && last_dir)))
    else $error("new centre loaded while directions still pending");
`endif
endmodule

/* design/directional_difference_stencil_unit.sv */
// Top level of the directional difference stencil.
// pixel_in takes one raster pixel (or pad beat) of a plane per beat; result_out
// gives one beat per configured direction for each centre pixel, which lags the
// input by MAX_OFFSET rows plus MAX_OFFSET columns. The last beat of a centre
// has last set. The first MAX_OFFSET*W+MAX_OFFSET beats of a plane give no
// result; after the H*W pixels the same number of pad beats drain the plane.
// After a centre is loaded, the next item is not taken until all its configured
// directions have issued, as the neighbour line store has one read port; warm-up
// items do not hold it. Each result passes the sequencer, the registered line
// store reads and a two-entry result queue, which lets input continue while
// result_out is stalled; once full, the sequencer halts and pixel_in.ready
// drops. After reset and after every configuration write, ready is held low
// while the registered geometry settles and the raster position is rederived
// for the new geometry. Configuration is written through cfg_we, cfg_index and
// cfg_data by the user while the block is idle; the block does not enforce it.
module directional_difference_stencil_unit (
  input  logic                       clk,
  input  logic                       rst,
  dds_in_if.sink                     pixel_in,
  dds_out_if.source                  result_out,
  input  logic                       cfg_we,
  input  logic [dds_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dds_pkg::CFG_W-1:0]  cfg_data
);
  import dds_pkg::*;

  logic                  run, free, accept, wr_en, load;
  geom_t                 geom;
  centre_t               centre;
  logic [ADDR_W-1:0]     wr_addr, nbr_addr, centre_addr;
  logic [PIXEL_BITS-1:0] wr_data, nbr_data, centre_data;

  assign pixel_in.ready = run && free;
  assign accept         = pixel_in.valid && pixel_in.ready;

  dds_stream u_stream (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pixel_value (pixel_in.pixel_value),
    .pad         (pixel_in.pad),
    .run         (run),
    .geom        (geom),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .load        (load),
    .centre      (centre)
  );

  dds_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RING_DEPTH)) u_nbr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (nbr_addr),
    .rdata (nbr_data)
  );

  dds_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RING_DEPTH)) u_centre_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (centre_addr),
    .rdata (centre_data)
  );

  dds_issue u_issue (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .load        (load),
    .centre      (centre),
    .free        (free),
    .nbr_addr    (nbr_addr),
    .centre_addr (centre_addr),
    .nbr_data    (nbr_data),
    .centre_data (centre_data),
    .result_out  (result_out)
  );
endmodule
